// ----- hw/rtl/fnas_pkg.sv -----
package fnas_pkg;

  localparam int unsigned DEFAULT_MAX_COLS = 1024;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned CFG_COLS_W = 11;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [ROW_W-1:0]      GRID_ROWS_RESET = 16'd1024;
  localparam logic [CFG_COLS_W-1:0] GRID_COLS_RESET = 11'd1024;
  localparam logic [ROW_W-1:0]      MIN_ROWS        = 16'd3;
  localparam logic [CFG_COLS_W-1:0] MIN_COLS        = 11'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } cfg_reg_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// ----- hw/rtl/four_neighbor_average_stencil_top.sv -----
// channel  direction  handshake               payload
// in       request in  in_valid_i/in_stall_o   sample_i
// out      request out out_valid_o/out_stall_i average_o, out_row_o, out_col_o, frame_last_o
// cfg      write in    cfg_we_i                cfg_index_i, cfg_wdata_i
//
// One request per cycle unless stalled; each result passes compute, then output registers.
// The line store is read one column ahead and written at the current column each request.
// Reset clears counters, geometry and handshake state; the line store needs no clearing.
// A stall on the output holds the compute stage and then the input.
module four_neighbor_average_stencil_top
  import fnas_pkg::*;
#(
  parameter int unsigned MAX_COLS = DEFAULT_MAX_COLS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  sample_t                 sample_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output sample_t                 average_o,
  output logic [ROW_W-1:0]        out_row_o,
  output logic [$clog2(MAX_COLS)-1:0] out_col_o,
  output logic                    frame_last_o
);

  localparam int unsigned AW = $clog2(MAX_COLS);
  localparam int unsigned CW = $clog2(MAX_COLS + 1);

  logic [ROW_W-1:0]      grid_rows_q;
  logic [CFG_COLS_W-1:0] grid_cols_q;
  logic [ROW_W-1:0]      eff_rows;
  logic [CFG_COLS_W-1:0] cols_min;
  logic [CW-1:0]         eff_cols;

  logic [ROW_W-1:0] row_q, row_d;
  logic [AW-1:0]    col_q, col_d;
  logic             col_last, row_last, emit, cell_last;
  logic [AW-1:0]    rd_addr;
  logic             in_acc;

  sample_t above_mem [MAX_COLS];
  sample_t two_above_mem [MAX_COLS];
  sample_t rd_above_q, rd_two_q;
  sample_t west_q;

  logic             b_valid_q, b_valid_d;
  sample_t          b_sample_q, b_north_q, b_west_q;
  logic [ROW_W-1:0] b_row_q;
  logic [AW-1:0]    b_col_q;
  logic             b_last_q;
  logic             b_ready, b_move;
  logic signed [SAMPLE_W+1:0] b_sum;

  logic             out_valid_q, out_valid_d, out_free;
  sample_t          out_avg_q;
  logic [ROW_W-1:0] out_row_q;
  logic [AW-1:0]    out_col_q;
  logic             out_last_q;

  always_comb begin
    eff_rows = (grid_rows_q < MIN_ROWS) ? MIN_ROWS : grid_rows_q;
    cols_min = (grid_cols_q < MIN_COLS) ? MIN_COLS : grid_cols_q;
    if (32'(cols_min) > MAX_COLS) begin
      eff_cols = CW'(MAX_COLS);
    end else begin
      eff_cols = CW'(cols_min);
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign b_ready    = !b_valid_q || out_free;
  assign b_move     = b_valid_q && out_free;
  assign in_stall_o = !b_ready;
  assign in_acc     = in_valid_i && b_ready;

  always_comb begin
    col_last  = (CW'(col_q) + CW'(1)) == eff_cols;
    row_last  = ({1'b0, row_q} + 17'd1) == {1'b0, eff_rows};
    emit      = (row_q >= ROW_W'(2)) && (col_q != '0) && !col_last;
    cell_last = row_last && ((CW'(col_q) + CW'(2)) == eff_cols);
    rd_addr   = col_last ? '0 : col_q + AW'(1);
    col_d     = rd_addr;
    row_d     = row_q;
    if (col_last) begin
      row_d = row_last ? '0 : row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= GRID_ROWS_RESET;
      grid_cols_q <= GRID_COLS_RESET;
      row_q       <= '0;
      col_q       <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GRID_ROWS: grid_rows_q <= cfg_wdata_i[ROW_W-1:0];
        REG_GRID_COLS: grid_cols_q <= cfg_wdata_i[CFG_COLS_W-1:0];
        default: ;
      endcase
      row_q <= '0;
      col_q <= '0;
    end else if (in_acc) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // shift the column down one row, fetch the next column
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      above_mem[col_q]     <= sample_i;
      two_above_mem[col_q] <= rd_above_q;
      rd_above_q           <= above_mem[rd_addr];
      rd_two_q             <= two_above_mem[rd_addr];
      west_q               <= rd_above_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      b_sample_q <= sample_i;
      b_north_q  <= rd_two_q;
      b_west_q   <= west_q;
      b_row_q    <= row_q - ROW_W'(1);
      b_col_q    <= col_q;
      b_last_q   <= cell_last;
    end
  end

  assign b_sum = {{2{b_sample_q[SAMPLE_W-1]}}, b_sample_q}
               + {{2{b_north_q[SAMPLE_W-1]}}, b_north_q}
               + {{2{b_west_q[SAMPLE_W-1]}}, b_west_q}
               + {{2{rd_above_q[SAMPLE_W-1]}}, rd_above_q};

  always_comb begin
    b_valid_d = b_valid_q;
    if (in_acc) begin
      b_valid_d = emit;
    end else if (b_move) begin
      b_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (b_move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b_valid_q   <= b_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_move) begin
      out_avg_q  <= b_sum[SAMPLE_W+1:2];
      out_row_q  <= b_row_q;
      out_col_q  <= b_col_q;
      out_last_q <= b_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign average_o    = out_avg_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign frame_last_o = out_last_q;

endmodule

// ----- test/fnas_scoreboard_pkg.sv -----
package fnas_scoreboard_pkg;
  import fnas_pkg::*;

  localparam int unsigned COL_W = $clog2(DEFAULT_MAX_COLS);

  typedef struct {
    sample_t          average;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } cell_result_t;

  class stencil_scoreboard;
    logic [SAMPLE_W-1:0]   line_above[DEFAULT_MAX_COLS];
    logic [SAMPLE_W-1:0]   line_two_above[DEFAULT_MAX_COLS];
    logic [SAMPLE_W-1:0]   west_q;
    logic [SAMPLE_W-1:0]   centre_q;
    int unsigned           row_pos;
    int unsigned           col_pos;
    logic [ROW_W-1:0]      rows_reg;
    logic [CFG_COLS_W-1:0] cols_reg;
    cell_result_t          cells_due[$];
    int unsigned           mismatches;

    function new();
      rows_reg   = GRID_ROWS_RESET;
      cols_reg   = GRID_COLS_RESET;
      west_q     = '0;
      centre_q   = '0;
      row_pos    = 0;
      col_pos    = 0;
      mismatches = 0;
    endfunction

    function int unsigned live_rows();
      return (rows_reg < MIN_ROWS) ? int'(MIN_ROWS) : int'(rows_reg);
    endfunction

    function int unsigned live_cols();
      int unsigned c;
      c = (cols_reg < MIN_COLS) ? int'(MIN_COLS) : int'(cols_reg);
      if (c > DEFAULT_MAX_COLS) c = DEFAULT_MAX_COLS;
      return c;
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    // restart the frame; line contents stay
    function void write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
      if (idx == REG_GRID_ROWS) begin
        rows_reg = data;
      end else begin
        cols_reg = data[CFG_COLS_W-1:0];
      end
      row_pos = 0;
      col_pos = 0;
    endfunction

    function void note_sample(sample_t s);
      int unsigned         nrows;
      int unsigned         ncols;
      int unsigned         r;
      int unsigned         c;
      logic [SAMPLE_W-1:0] north;
      logic [SAMPLE_W-1:0] east;
      logic [SAMPLE_W-1:0] centre;
      logic [33:0]         sum;
      cell_result_t        due;
      nrows = live_rows();
      ncols = live_cols();
      r = row_pos;
      c = col_pos;
      if (c >= ncols) c = 0;
      if (r >= nrows) r = 0;
      centre = (c == 0) ? line_above[0] : centre_q;
      north  = line_two_above[c];
      east   = (c + 1 < ncols) ? line_above[c+1] : '0;
      if (r >= 2 && c >= 1 && c + 1 < ncols) begin
        sum = {{2{north[31]}}, north} + {{2{s[31]}}, s}
            + {{2{west_q[31]}}, west_q} + {{2{east[31]}}, east};
        due.average = sum[33:2];
        due.row     = ROW_W'(r - 1);
        due.col     = COL_W'(c);
        due.last    = (r + 1 == nrows) && (c + 2 == ncols);
        cells_due   = {cells_due, due};
      end
      line_two_above[c] = line_above[c];
      line_above[c]     = s;
      west_q            = centre;
      centre_q          = east;
      c++;
      if (c >= ncols) begin
        c = 0;
        r++;
        if (r >= nrows) r = 0;
      end
      col_pos = c;
      row_pos = r;
    endfunction

    task check_result(sample_t avg, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                      logic last);
      cell_result_t want;
      if (cells_due.size() == 0) begin
        report($sformatf("result with nothing due: avg %h row %0d col %0d", avg, row, col));
        return;
      end
      want = cells_due.pop_front();
      if (avg !== want.average)
        report($sformatf("average %h, want %h (row %0d col %0d)", avg, want.average,
                         want.row, want.col));
      if (row !== want.row) report($sformatf("out_row %0d, want %0d", row, want.row));
      if (col !== want.col) report($sformatf("out_col %0d, want %0d", col, want.col));
      if (last !== want.last)
        report($sformatf("frame_last %b, want %b (row %0d col %0d)", last, want.last,
                         want.row, want.col));
    endtask
  endclass

endpackage

// ----- test/four_neighbor_average_stencil_top_tb.sv -----
module four_neighbor_average_stencil_top_tb;
  import fnas_pkg::*;
  import fnas_scoreboard_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 1920;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_GRID_ROWS;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  sample_t              sample_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  sample_t              average_o;
  logic [ROW_W-1:0]     out_row_o;
  logic [COL_W-1:0]     out_col_o;
  logic                 frame_last_o;

  stencil_scoreboard sb = new();
  bit                steady = 1'b0;
  int unsigned       cycle_count = 0;

  four_neighbor_average_stencil_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .average_o    (average_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .frame_last_o (frame_last_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned hold;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      sb.check_result(average_o, out_row_o, out_col_o, frame_last_o);
      @(negedge clk_i);
    end
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return sample_t'(int'($urandom_range(0, 15)) - 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_sample(input sample_t value, input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= value;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_sample(value);
    @(negedge clk_i);
  endtask

  task automatic drain_requests(input int unsigned tail);
    @(negedge clk_i);
    while (sb.cells_due.size() != 0) @(negedge clk_i);
    repeat (tail) @(negedge clk_i);
  endtask

  task automatic configure(input logic [CFG_W-1:0] rows_data, input logic [CFG_W-1:0] cols_data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_GRID_ROWS;
    cfg_wdata_i <= rows_data;
    @(negedge clk_i);
    sb.write_reg(REG_GRID_ROWS, rows_data);
    cfg_index_i <= REG_GRID_COLS;
    cfg_wdata_i <= cols_data;
    @(negedge clk_i);
    sb.write_reg(REG_GRID_COLS, cols_data);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] rows_data, input logic [CFG_W-1:0] cols_data,
                           input int unsigned count, input bit pause_mid);
    configure(rows_data, cols_data);
    steady = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < count; i++) begin
      // hold off until every result is out
      if (pause_mid && i == count / 2) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (sb.cells_due.size() != 0) @(negedge clk_i);
      end
      send_sample(pick_sample(), steady ? 0 : $urandom_range(0, 3));
    end
    in_valid_i <= 1'b0;
    drain_requests(8);
  endtask

  initial begin
    sample_t          corner_frame[9];
    int unsigned      sent;
    int unsigned      rows_pick;
    int unsigned      cols_pick;
    int unsigned      area;
    int unsigned      count;
    logic [CFG_W-1:0] rows_data;
    logic [CFG_W-1:0] cols_data;

    corner_frame = '{32'h0, 32'hFFFF_FFFF, 32'h0,
                     32'h8000_0000, 32'd123, 32'h7FFF_FFFF,
                     32'd5, 32'hFFFF_FFFE, 32'd9};

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // smallest grid: all max, all min, then mixed signs
    configure(16'd0, 16'd2);
    for (int i = 0; i < 9; i++) send_sample(32'h7FFF_FFFF, $urandom_range(0, 3));
    for (int i = 0; i < 9; i++) send_sample(32'h8000_0000, $urandom_range(0, 3));
    for (int i = 0; i < 9; i++) send_sample(corner_frame[i], $urandom_range(0, 3));
    in_valid_i <= 1'b0;
    drain_requests(8);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin
          rows_pick = 65535;
          cols_pick = $urandom_range(3, 12);
          count     = cols_pick * $urandom_range(3, 6);
        end
        1: begin
          rows_pick = $urandom_range(0, 2);
          cols_pick = $urandom_range(0, 2);
          count     = 9 * $urandom_range(2, 5) + $urandom_range(0, 8);
        end
        default: begin
          rows_pick = $urandom_range(3, 9);
          cols_pick = $urandom_range(3, 20);
          area      = rows_pick * cols_pick;
          count     = area * $urandom_range(1, 3) + $urandom_range(0, area - 1);
        end
      endcase
      if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
      rows_data = CFG_W'(rows_pick);
      cols_data = {5'($urandom), CFG_COLS_W'(cols_pick)};
      run_phase(rows_data, cols_data, count, (sent == 0) || ($urandom_range(0, 3) == 0));
      sent += count;
    end

    drain_requests(20);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/fnas_pkg.sv
hw/rtl/four_neighbor_average_stencil_top.sv
test/fnas_scoreboard_pkg.sv
test/four_neighbor_average_stencil_top_tb.sv
